// ===== src/dsf_pkg.sv =====
package dsf_pkg;

  // Field widths of one spring request and of one result.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned CFG_W   = 32;

  // Square root of the 65-bit squared distance, padded to an even width.
  localparam int unsigned SQ_IN_W    = 66;
  localparam int unsigned DIST_W     = SQ_IN_W / 2;
  localparam int unsigned SQRT_STEPS = DIST_W;

  // Unit vector components are unsigned Q1.30 magnitudes of at most 1.0.
  localparam int unsigned UNIT_BITS = 30;
  localparam int unsigned UNIT_W    = UNIT_BITS + 1;
  localparam int unsigned DIV_STEPS = UNIT_W;
  localparam int unsigned FRAC_BITS = 16;

  // Register reset values in unsigned Q16.16.
  localparam logic [CFG_W-1:0] STIFFNESS_RST   = 32'd3276800;
  localparam logic [CFG_W-1:0] DAMPING_RST     = 32'd6554;
  localparam logic [CFG_W-1:0] MAX_STRETCH_RST = 32'd9830;
  localparam logic [CFG_W-1:0] MIN_BREAK_RST   = 32'd655360;

  typedef enum logic [1:0] {
    CFG_STIFFNESS   = 2'd0,
    CFG_DAMPING     = 2'd1,
    CFG_MAX_STRETCH = 2'd2,
    CFG_MIN_BREAK   = 2'd3
  } cfg_reg_e;

endpackage

// ===== src/dsf_sqrt.sv =====
module dsf_sqrt #(
  parameter int unsigned RAD_W = 66,
  parameter int unsigned TAG_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [RAD_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               vld_o,
  output logic [RAD_W/2-1:0] root_o,
  output logic [TAG_W-1:0]   tag_o
);

  localparam int unsigned OW  = RAD_W / 2;
  localparam int unsigned RMW = OW + 2;

  logic             vld_q  [OW];
  logic [RAD_W-1:0] rad_q  [OW];
  logic [RMW-1:0]   rem_q  [OW];
  logic [OW-1:0]    root_q [OW];
  logic [TAG_W-1:0] tag_q  [OW];

  // One root bit per stage: bring down two radicand bits and try 4*root+1.
  for (genvar k = 0; k < OW; k++) begin : g_step
    logic             vld_in;
    logic [RAD_W-1:0] rad_in;
    logic [RMW-1:0]   rem_in;
    logic [OW-1:0]    root_in;
    logic [TAG_W-1:0] tag_in;
    logic [RMW+1:0]   cur;
    logic [RMW+1:0]   trial;
    logic             ge;
    logic [RMW+1:0]   rem_d;
    logic [OW-1:0]    root_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    assign cur    = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = cur >= trial;
    assign rem_d  = ge ? (cur - trial) : cur;
    assign root_d = {root_in[OW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      rem_q[k]  <= rem_d[RMW-1:0];
      root_q[k] <= root_d;
      tag_q[k]  <= tag_in;
    end
  end

  assign vld_o  = vld_q[OW-1];
  assign root_o = root_q[OW-1];
  assign tag_o  = tag_q[OW-1];

endmodule

// ===== src/dsf_div.sv =====
module dsf_div #(
  parameter int unsigned DW    = 33,
  parameter int unsigned QW    = 31,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [DW-1:0]    num_a_i,
  input  logic [DW-1:0]    num_b_i,
  input  logic [DW-1:0]    den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [QW-1:0]    quo_a_o,
  output logic [QW-1:0]    quo_b_o,
  output logic [TAG_W-1:0] tag_o
);

  // Both numerators are at most the divisor, so each quotient has QW bits
  // once QW-1 zero bits are appended to the numerator.
  logic             vld_q [QW];
  logic [DW-1:0]    den_q [QW];
  logic [DW-1:0]    ra_q  [QW];
  logic [DW-1:0]    rb_q  [QW];
  logic [QW-1:0]    qa_q  [QW];
  logic [QW-1:0]    qb_q  [QW];
  logic [TAG_W-1:0] tag_q [QW];

  // Restoring division, one quotient bit per stage for both lanes.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic             vld_in;
    logic [DW-1:0]    den_in;
    logic [DW-1:0]    ra_in;
    logic [DW-1:0]    rb_in;
    logic [QW-1:0]    qa_in;
    logic [QW-1:0]    qb_in;
    logic [TAG_W-1:0] tag_in;
    logic [DW:0]      sha;
    logic [DW:0]      shb;
    logic [DW:0]      den_ext;
    logic             gea;
    logic             geb;
    logic [DW:0]      ra_d;
    logic [DW:0]      rb_d;

    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign den_in = den_i;
      assign ra_in  = num_a_i;
      assign rb_in  = num_b_i;
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign tag_in = tag_i;
      assign sha    = {1'b0, ra_in};
      assign shb    = {1'b0, rb_in};
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign den_in = den_q[k-1];
      assign ra_in  = ra_q[k-1];
      assign rb_in  = rb_q[k-1];
      assign qa_in  = qa_q[k-1];
      assign qb_in  = qb_q[k-1];
      assign tag_in = tag_q[k-1];
      assign sha    = {ra_in, 1'b0};
      assign shb    = {rb_in, 1'b0};
    end

    assign den_ext = {1'b0, den_in};
    assign gea     = sha >= den_ext;
    assign geb     = shb >= den_ext;
    assign ra_d    = gea ? (sha - den_ext) : sha;
    assign rb_d    = geb ? (shb - den_ext) : shb;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[k] <= den_in;
      ra_q[k]  <= ra_d[DW-1:0];
      rb_q[k]  <= rb_d[DW-1:0];
      qa_q[k]  <= {qa_in[QW-2:0], gea};
      qb_q[k]  <= {qb_in[QW-2:0], geb};
      tag_q[k] <= tag_in;
    end
  end

  assign vld_o   = vld_q[QW-1];
  assign quo_a_o = qa_q[QW-1];
  assign quo_b_o = qb_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== src/damped_spring_force_unit.sv =====
// Each accepted request leads to its own result strobe.
// Throughput: one spring per cycle; busy never rises.
// The depth is set by the bit-per-stage square root (33 stages) and the
// bit-per-stage unit vector divider (31 stages), plus 14 arithmetic stages.
// Reset clears all valid bits and loads the default coefficients.
// Results appear for one cycle only; the receiver cannot stall the pipeline.
module damped_spring_force_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  dsf_pkg::cfg_reg_e       cfg_index_i,
  input  logic [31:0]             cfg_wdata_i,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      first_pos_x_i,
  input  logic signed [31:0]      first_pos_y_i,
  input  logic signed [31:0]      second_pos_x_i,
  input  logic signed [31:0]      second_pos_y_i,
  input  logic signed [31:0]      first_vel_x_i,
  input  logic signed [31:0]      first_vel_y_i,
  input  logic signed [31:0]      second_vel_x_i,
  input  logic signed [31:0]      second_vel_y_i,
  input  logic [30:0]             rest_length_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      force_x_o,
  output logic signed [31:0]      force_y_o,
  output logic                    broken_o,
  output logic                    zero_distance_o
);

  import dsf_pkg::*;

  localparam int unsigned LATENCY   = 3 + SQRT_STEPS + 2 + DIV_STEPS + 9;
  localparam int unsigned SQ_TAG_W  = 2 + 2 * COORD_W + 2 * DIFF_W + LEN_W + CFG_W + LEN_W;
  localparam int unsigned DIV_TAG_W = DIST_W + 5 + 2 * DIFF_W;

  function automatic logic [31:0] sat_force(input logic [51:0] mag, input logic neg);
    if (neg) begin
      if (mag > 52'h0_0000_8000_0000) return 32'h8000_0000;
      return ~mag[31:0] + 32'd1;
    end
    if (mag > 52'h0_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // The pipeline never holds off a request.
  assign busy = 1'b0;

  // Coefficient registers.
  logic [CFG_W-1:0] stiffness_q, damping_q, max_stretch_q, min_break_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q   <= STIFFNESS_RST;
      damping_q     <= DAMPING_RST;
      max_stretch_q <= MAX_STRETCH_RST;
      min_break_q   <= MIN_BREAK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STIFFNESS:   stiffness_q   <= cfg_wdata_i;
        CFG_DAMPING:     damping_q     <= cfg_wdata_i;
        CFG_MAX_STRETCH: max_stretch_q <= cfg_wdata_i;
        CFG_MIN_BREAK:   min_break_q   <= cfg_wdata_i;
        default:         stiffness_q   <= stiffness_q;
      endcase
    end
  end

  // Valid bits of the arithmetic stages around the two iterative units.
  logic a_vld_q, b_vld_q, c_vld_q, d1_vld_q, d2_vld_q;
  logic e_vld_q, f_vld_q, g_vld_q, h_vld_q, i_vld_q, j_vld_q, k_vld_q, l_vld_q, m_vld_q;
  logic sq_vld, dv_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      e_vld_q  <= 1'b0;
      f_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      h_vld_q  <= 1'b0;
      i_vld_q  <= 1'b0;
      j_vld_q  <= 1'b0;
      k_vld_q  <= 1'b0;
      l_vld_q  <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      a_vld_q  <= start;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      d1_vld_q <= sq_vld;
      d2_vld_q <= d1_vld_q;
      e_vld_q  <= dv_vld;
      f_vld_q  <= e_vld_q;
      g_vld_q  <= f_vld_q;
      h_vld_q  <= g_vld_q;
      i_vld_q  <= h_vld_q;
      j_vld_q  <= i_vld_q;
      k_vld_q  <= j_vld_q;
      l_vld_q  <= k_vld_q;
      m_vld_q  <= l_vld_q;
    end
  end

  // Stage A: position and velocity differences.
  logic [DIFF_W-1:0] a_dx_q, a_dy_q, a_dvx_q, a_dvy_q;
  logic [LEN_W-1:0]  a_len_q;

  always_ff @(posedge clk_i) begin
    a_dx_q  <= {first_pos_x_i[31], first_pos_x_i} - {second_pos_x_i[31], second_pos_x_i};
    a_dy_q  <= {first_pos_y_i[31], first_pos_y_i} - {second_pos_y_i[31], second_pos_y_i};
    a_dvx_q <= {first_vel_x_i[31], first_vel_x_i} - {second_vel_x_i[31], second_vel_x_i};
    a_dvy_q <= {first_vel_y_i[31], first_vel_y_i} - {second_vel_y_i[31], second_vel_y_i};
    a_len_q <= rest_length_i;
  end

  // Stage B: magnitudes, their squares and the scaled break threshold.
  logic [COORD_W-1:0]   b_ax_d, b_ay_d, b_ax_q, b_ay_q;
  logic [2*COORD_W-1:0] b_sa_q, b_sb_q;
  logic                 b_dxneg_q, b_dyneg_q;
  logic [DIFF_W-1:0]    b_dvx_q, b_dvy_q;
  logic [LEN_W-1:0]     b_len_q;
  logic [CFG_W+LEN_W-1:0] b_mslen_q;

  assign b_ax_d = a_dx_q[DIFF_W-1] ? (~a_dx_q[COORD_W-1:0] + 32'd1) : a_dx_q[COORD_W-1:0];
  assign b_ay_d = a_dy_q[DIFF_W-1] ? (~a_dy_q[COORD_W-1:0] + 32'd1) : a_dy_q[COORD_W-1:0];

  always_ff @(posedge clk_i) begin
    b_sa_q    <= {32'd0, b_ax_d} * {32'd0, b_ax_d};
    b_sb_q    <= {32'd0, b_ay_d} * {32'd0, b_ay_d};
    b_ax_q    <= b_ax_d;
    b_ay_q    <= b_ay_d;
    b_dxneg_q <= a_dx_q[DIFF_W-1];
    b_dyneg_q <= a_dy_q[DIFF_W-1];
    b_dvx_q   <= a_dvx_q;
    b_dvy_q   <= a_dvy_q;
    b_len_q   <= a_len_q;
    b_mslen_q <= {31'd0, max_stretch_q} * {32'd0, a_len_q};
  end

  // Stage C: squared distance.
  logic [SQ_IN_W-1:0]  c_sum_q;
  logic [SQ_TAG_W-1:0] c_tag_q;

  always_ff @(posedge clk_i) begin
    c_sum_q <= {2'b00, b_sa_q} + {2'b00, b_sb_q};
    c_tag_q <= {b_dxneg_q, b_dyneg_q, b_ax_q, b_ay_q, b_dvx_q, b_dvy_q, b_len_q, b_mslen_q};
  end

  // Distance |d| as the floor of the square root.
  logic [DIST_W-1:0]      sq_root;
  logic [SQ_TAG_W-1:0]    sq_tag;
  logic                   sq_dxneg, sq_dyneg;
  logic [COORD_W-1:0]     sq_ax, sq_ay;
  logic [DIFF_W-1:0]      sq_dvx, sq_dvy;
  logic [LEN_W-1:0]       sq_len;
  logic [CFG_W+LEN_W-1:0] sq_mslen;

  dsf_sqrt #(
    .RAD_W (SQ_IN_W),
    .TAG_W (SQ_TAG_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c_vld_q),
    .rad_i  (c_sum_q),
    .tag_i  (c_tag_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  assign {sq_dxneg, sq_dyneg, sq_ax, sq_ay, sq_dvx, sq_dvy, sq_len, sq_mslen} = sq_tag;

  // Stage D1: stretch and the length and zero tests.
  logic [DIST_W:0]        d1_s_q;
  logic                   d1_zero_q, d1_lenok_q, d1_dxneg_q, d1_dyneg_q;
  logic [COORD_W-1:0]     d1_ax_q, d1_ay_q;
  logic [DIST_W-1:0]      d1_n_q;
  logic [DIFF_W-1:0]      d1_dvx_q, d1_dvy_q;
  logic [CFG_W+LEN_W-1:0] d1_mslen_q;

  always_ff @(posedge clk_i) begin
    d1_s_q     <= {1'b0, sq_root} - {3'b000, sq_len};
    d1_zero_q  <= sq_root == '0;
    d1_lenok_q <= {1'b0, sq_len} > min_break_q;
    d1_dxneg_q <= sq_dxneg;
    d1_dyneg_q <= sq_dyneg;
    d1_ax_q    <= sq_ax;
    d1_ay_q    <= sq_ay;
    d1_n_q     <= sq_root;
    d1_dvx_q   <= sq_dvx;
    d1_dvy_q   <= sq_dvy;
    d1_mslen_q <= sq_mslen;
  end

  // Stage D2: stretch magnitude and the break decision.
  logic [DIST_W-1:0]    d2_sm_d, d2_sm_q;
  logic                 d2_brk_d, d2_brk_q, d2_sneg_q, d2_zero_q;
  logic                 d2_dxneg_q, d2_dyneg_q;
  logic [COORD_W-1:0]   d2_ax_q, d2_ay_q;
  logic [DIST_W-1:0]    d2_n_q;
  logic [DIFF_W-1:0]    d2_dvx_q, d2_dvy_q;

  assign d2_sm_d  = d1_s_q[DIST_W] ? (~d1_s_q[DIST_W-1:0] + 33'd1) : d1_s_q[DIST_W-1:0];
  assign d2_brk_d = ({14'd0, d2_sm_d, 16'd0} > d1_mslen_q) && d1_lenok_q;

  always_ff @(posedge clk_i) begin
    d2_sm_q    <= d2_sm_d;
    d2_brk_q   <= d2_brk_d;
    d2_sneg_q  <= d1_s_q[DIST_W];
    d2_zero_q  <= d1_zero_q;
    d2_dxneg_q <= d1_dxneg_q;
    d2_dyneg_q <= d1_dyneg_q;
    d2_ax_q    <= d1_ax_q;
    d2_ay_q    <= d1_ay_q;
    d2_n_q     <= d1_n_q;
    d2_dvx_q   <= d1_dvx_q;
    d2_dvy_q   <= d1_dvy_q;
  end

  // Unit vector magnitudes |d_i| * 2^30 / |d|.
  logic [UNIT_W-1:0]    dv_qa, dv_qb;
  logic [DIV_TAG_W-1:0] dv_tag;
  logic [DIST_W-1:0]    dv_sm;
  logic                 dv_sneg, dv_brk, dv_zero, dv_dxneg, dv_dyneg;
  logic [DIFF_W-1:0]    dv_dvx, dv_dvy;

  dsf_div #(
    .DW    (DIST_W),
    .QW    (UNIT_W),
    .TAG_W (DIV_TAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (d2_vld_q),
    .num_a_i ({1'b0, d2_ax_q}),
    .num_b_i ({1'b0, d2_ay_q}),
    .den_i   (d2_n_q),
    .tag_i   ({d2_sm_q, d2_sneg_q, d2_brk_q, d2_zero_q, d2_dxneg_q, d2_dyneg_q,
               d2_dvx_q, d2_dvy_q}),
    .vld_o   (dv_vld),
    .quo_a_o (dv_qa),
    .quo_b_o (dv_qb),
    .tag_o   (dv_tag)
  );

  assign {dv_sm, dv_sneg, dv_brk, dv_zero, dv_dxneg, dv_dyneg, dv_dvx, dv_dvy} = dv_tag;

  // Stage E: velocity projections and the spring term k*s.
  logic signed [64:0] e_px_d, e_py_d;
  logic [64:0]        e_hook_d;
  logic [64:0]        e_px_q, e_py_q;
  logic [48:0]        e_hook_q;
  logic               e_sneg_q, e_brk_q, e_zero_q, e_dxneg_q, e_dyneg_q;
  logic [UNIT_W-1:0]  e_ux_q, e_uy_q;

  assign e_px_d   = $signed({1'b0, dv_qa}) * $signed(dv_dvx);
  assign e_py_d   = $signed({1'b0, dv_qb}) * $signed(dv_dvy);
  assign e_hook_d = {33'd0, stiffness_q} * {32'd0, dv_sm};

  always_ff @(posedge clk_i) begin
    e_px_q    <= e_px_d;
    e_py_q    <= e_py_d;
    e_hook_q  <= e_hook_d[64:FRAC_BITS];
    e_sneg_q  <= dv_sneg;
    e_brk_q   <= dv_brk;
    e_zero_q  <= dv_zero;
    e_dxneg_q <= dv_dxneg;
    e_dyneg_q <= dv_dyneg;
    e_ux_q    <= dv_qa;
    e_uy_q    <= dv_qb;
  end

  // Stage F: relative speed along the spring in Q20.46.
  logic signed [65:0] f_tx, f_ty, f_pw_d;
  logic [65:0]        f_pw_q;
  logic [48:0]        f_hook_q;
  logic               f_sneg_q, f_brk_q, f_zero_q, f_dxneg_q, f_dyneg_q;
  logic [UNIT_W-1:0]  f_ux_q, f_uy_q;

  assign f_tx   = e_dxneg_q ? -$signed({e_px_q[64], e_px_q}) : $signed({e_px_q[64], e_px_q});
  assign f_ty   = e_dyneg_q ? -$signed({e_py_q[64], e_py_q}) : $signed({e_py_q[64], e_py_q});
  assign f_pw_d = f_tx + f_ty;

  always_ff @(posedge clk_i) begin
    f_pw_q    <= f_pw_d;
    f_hook_q  <= e_hook_q;
    f_sneg_q  <= e_sneg_q;
    f_brk_q   <= e_brk_q;
    f_zero_q  <= e_zero_q;
    f_dxneg_q <= e_dxneg_q;
    f_dyneg_q <= e_dyneg_q;
    f_ux_q    <= e_ux_q;
    f_uy_q    <= e_uy_q;
  end

  // Stage G: speed magnitude truncated to Q16.16.
  logic [65:0]        g_pwabs_d;
  logic [DIST_W-1:0]  g_wm_q;
  logic               g_pwneg_q;
  logic [48:0]        g_hook_q;
  logic               g_sneg_q, g_brk_q, g_zero_q, g_dxneg_q, g_dyneg_q;
  logic [UNIT_W-1:0]  g_ux_q, g_uy_q;

  assign g_pwabs_d = f_pw_q[65] ? (~f_pw_q + 66'd1) : f_pw_q;

  always_ff @(posedge clk_i) begin
    g_wm_q    <= g_pwabs_d[UNIT_BITS+DIST_W-1:UNIT_BITS];
    g_pwneg_q <= f_pw_q[65];
    g_hook_q  <= f_hook_q;
    g_sneg_q  <= f_sneg_q;
    g_brk_q   <= f_brk_q;
    g_zero_q  <= f_zero_q;
    g_dxneg_q <= f_dxneg_q;
    g_dyneg_q <= f_dyneg_q;
    g_ux_q    <= f_ux_q;
    g_uy_q    <= f_uy_q;
  end

  // Stage H: damping term c*w.
  logic [64:0]        h_damp_d;
  logic [48:0]        h_damp_q, h_hook_q;
  logic               h_pwneg_q, h_sneg_q, h_brk_q, h_zero_q, h_dxneg_q, h_dyneg_q;
  logic [UNIT_W-1:0]  h_ux_q, h_uy_q;

  assign h_damp_d = {33'd0, damping_q} * {32'd0, g_wm_q};

  always_ff @(posedge clk_i) begin
    h_damp_q  <= h_damp_d[64:FRAC_BITS];
    h_hook_q  <= g_hook_q;
    h_pwneg_q <= g_pwneg_q;
    h_sneg_q  <= g_sneg_q;
    h_brk_q   <= g_brk_q;
    h_zero_q  <= g_zero_q;
    h_dxneg_q <= g_dxneg_q;
    h_dyneg_q <= g_dyneg_q;
    h_ux_q    <= g_ux_q;
    h_uy_q    <= g_uy_q;
  end

  // Stage I: signed sum of the spring and damping terms.
  logic [51:0]        i_th, i_td;
  logic [51:0]        i_total_q;
  logic               i_brk_q, i_zero_q, i_dxneg_q, i_dyneg_q;
  logic [UNIT_W-1:0]  i_ux_q, i_uy_q;

  assign i_th = h_sneg_q  ? (~{3'b000, h_hook_q} + 52'd1) : {3'b000, h_hook_q};
  assign i_td = h_pwneg_q ? (~{3'b000, h_damp_q} + 52'd1) : {3'b000, h_damp_q};

  always_ff @(posedge clk_i) begin
    i_total_q <= i_th + i_td;
    i_brk_q   <= h_brk_q;
    i_zero_q  <= h_zero_q;
    i_dxneg_q <= h_dxneg_q;
    i_dyneg_q <= h_dyneg_q;
    i_ux_q    <= h_ux_q;
    i_uy_q    <= h_uy_q;
  end

  // Stage J: magnitude of the total and the sign of each component.
  logic [51:0]        j_tabs_d;
  logic [50:0]        j_tm_q;
  logic               j_negx_q, j_negy_q, j_brk_q, j_zero_q;
  logic [UNIT_W-1:0]  j_ux_q, j_uy_q;

  assign j_tabs_d = i_total_q[51] ? (~i_total_q + 52'd1) : i_total_q;

  always_ff @(posedge clk_i) begin
    j_tm_q   <= j_tabs_d[50:0];
    j_negx_q <= i_dxneg_q ^ i_total_q[51];
    j_negy_q <= i_dyneg_q ^ i_total_q[51];
    j_brk_q  <= i_brk_q;
    j_zero_q <= i_zero_q;
    j_ux_q   <= i_ux_q;
    j_uy_q   <= i_uy_q;
  end

  // Stage K: partial products of u_i * T, split at the unit fraction point.
  logic [51:0] k_phx_q, k_phy_q;
  logic [60:0] k_plx_q, k_ply_q;
  logic        k_negx_q, k_negy_q, k_brk_q, k_zero_q;

  always_ff @(posedge clk_i) begin
    k_phx_q  <= {21'd0, j_ux_q} * {31'd0, j_tm_q[50:UNIT_BITS]};
    k_phy_q  <= {21'd0, j_uy_q} * {31'd0, j_tm_q[50:UNIT_BITS]};
    k_plx_q  <= {30'd0, j_ux_q} * {31'd0, j_tm_q[UNIT_BITS-1:0]};
    k_ply_q  <= {30'd0, j_uy_q} * {31'd0, j_tm_q[UNIT_BITS-1:0]};
    k_negx_q <= j_negx_q;
    k_negy_q <= j_negy_q;
    k_brk_q  <= j_brk_q;
    k_zero_q <= j_zero_q;
  end

  // Stage L: force magnitudes in Q16.16.
  logic [51:0] l_magx_q, l_magy_q;
  logic        l_negx_q, l_negy_q, l_brk_q, l_zero_q;

  always_ff @(posedge clk_i) begin
    l_magx_q <= k_phx_q + {21'd0, k_plx_q[60:UNIT_BITS]};
    l_magy_q <= k_phy_q + {21'd0, k_ply_q[60:UNIT_BITS]};
    l_negx_q <= k_negx_q;
    l_negy_q <= k_negy_q;
    l_brk_q  <= k_brk_q;
    l_zero_q <= k_zero_q;
  end

  // Stage M: saturation, sign and the special cases into the result register.
  logic [31:0] m_fx_q, m_fy_q;
  logic        m_brk_q, m_zero_q;
  logic        l_flag;

  assign l_flag = l_brk_q || l_zero_q;

  always_ff @(posedge clk_i) begin
    m_fx_q   <= l_flag ? 32'd0 : sat_force(l_magx_q, l_negx_q);
    m_fy_q   <= l_flag ? 32'd0 : sat_force(l_magy_q, l_negy_q);
    m_brk_q  <= l_brk_q;
    m_zero_q <= l_zero_q && !l_brk_q;
  end

  assign result_valid_o  = m_vld_q;
  assign force_x_o       = m_fx_q;
  assign force_y_o       = m_fy_q;
  assign broken_o        = m_brk_q;
  assign zero_distance_o = m_zero_q;

`ifndef NO_ASSERTIONS
  // Every request produces its result at the end of the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY result_valid_o)
    else $error("request did not produce a result after the pipeline latency");

  // A spring that breaks is never also reported as coincident.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(broken_o && zero_distance_o))
    else $error("broken and zero distance flagged together");

  // A flagged result carries no force.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (broken_o || zero_distance_o)) |-> (force_x_o == 32'sd0 && force_y_o == 32'sd0))
    else $error("flagged result carries a nonzero force");
`endif

endmodule
